[design/assert_macros.svh]
// Assertion macros used by the checker module of the chi-square unit.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CHI_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never hold while out of reset.
`define CHI_ASSERT_NEVER(label, clk_s, rstn_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error(msg);

`endif

[design/chi2x2_pkg.sv]
// Package for the chi-square 2x2 unit: word types and fixed constants.
// No dependencies; used by the unit's modules apart from chi2x2_div and chi2x2_sqrt.
package chi2x2_pkg;

  localparam int CNT_W = 16;
  localparam int CHI_W = 32;
  localparam int PHI_W = 16;
  localparam int P_W   = 33;
  localparam int Z_W   = 20;

  localparam logic [Z_W-1:0] Z_LIMIT = 20'h80000;
  localparam logic [P_W-1:0] P_ONE   = 33'h1_0000_0000;

  localparam logic [31:0] POLY_Q32 [6] = '{
    32'd214178625, 32'd90799929, 32'd14077298,
    32'd163224, 32'd209984, 32'd23120
  };

  typedef struct packed {
    logic             op;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [CNT_W-1:0] count_c;
    logic [CNT_W-1:0] count_d;
  } in_word_t;

  typedef struct packed {
    logic [CHI_W-1:0] chi_square;
    logic [PHI_W-1:0] phi_coeff;
    logic [P_W-1:0]   p_two_sided;
    logic             div_error;
  } out_word_t;

endpackage

[design/chi2x2_front.sv]
// Front pipeline: margins, cross products, squared difference and divisor.
// Depends on chi2x2_pkg for the input word type.
module chi2x2_front #(
  parameter int CW = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  chi2x2_pkg::in_word_t    in_word,
  output logic                    out_valid,
  output logic                    out_op,
  output logic                    out_err,
  output logic [4*CW+3:0]         out_den,
  output logic [5*CW+15:0]        out_num_chi,
  output logic [4*CW+31:0]        out_num_phi
);

  localparam int DEN_W = 4*CW+4;
  localparam int SQ_W  = 4*CW;
  localparam int NS_W  = CW+2;
  localparam int NUM_W = 5*CW+16;

  logic [CW-1:0] a, b, c, d;
  logic [3:0] v_r;

  logic            f1_op_r;
  logic [CW:0]     f1_ab_r, f1_cd_r, f1_ac_r, f1_bd_r, f1_bcs_r;
  logic [NS_W-1:0] f1_n_r;
  logic [2*CW-1:0] f1_ad_r, f1_bc_r;
  logic [CW-1:0]   f1_mdiff_r;

  logic              f2_op_r;
  logic [2*CW-1:0]   f2_diff_r;
  logic [2*CW+1:0]   f2_p1_r, f2_p2_r;
  logic [NS_W-1:0]   f2_n_r;
  logic [CW:0]       f2_bcs_r;

  logic              f3_op_r;
  logic [DEN_W-1:0]  f3_den_r;
  logic [SQ_W-1:0]   f3_sq_r;
  logic [NS_W-1:0]   f3_n_r;

  logic              f4_op_r;
  logic              f4_err_r;
  logic [DEN_W-1:0]  f4_den_r;
  logic [NUM_W-1:0]  f4_num_chi_r;
  logic [SQ_W+31:0]  f4_num_phi_r;

  logic [2*CW-1:0]      diff_nxt;
  logic [SQ_W+NS_W-1:0] prod_nxt;

  assign a = in_word.count_a[CW-1:0];
  assign b = in_word.count_b[CW-1:0];
  assign c = in_word.count_c[CW-1:0];
  assign d = in_word.count_d[CW-1:0];

  assign diff_nxt = f1_op_r ? (2*CW)'(f1_mdiff_r) :
                    ((f1_ad_r > f1_bc_r) ? (f1_ad_r - f1_bc_r) : (f1_bc_r - f1_ad_r));
  assign prod_nxt = (SQ_W+NS_W)'(f3_sq_r) * (SQ_W+NS_W)'(f3_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    f1_op_r    <= in_word.op;
    f1_ab_r    <= (CW+1)'(a) + (CW+1)'(b);
    f1_cd_r    <= (CW+1)'(c) + (CW+1)'(d);
    f1_ac_r    <= (CW+1)'(a) + (CW+1)'(c);
    f1_bd_r    <= (CW+1)'(b) + (CW+1)'(d);
    f1_bcs_r   <= (CW+1)'(b) + (CW+1)'(c);
    f1_n_r     <= NS_W'(a) + NS_W'(b) + NS_W'(c) + NS_W'(d);
    f1_ad_r    <= (2*CW)'(a) * (2*CW)'(d);
    f1_bc_r    <= (2*CW)'(b) * (2*CW)'(c);
    f1_mdiff_r <= (b > c) ? (b - c) : (c - b);

    f2_op_r   <= f1_op_r;
    f2_diff_r <= diff_nxt;
    f2_p1_r   <= (2*CW+2)'(f1_ab_r) * (2*CW+2)'(f1_cd_r);
    f2_p2_r   <= (2*CW+2)'(f1_ac_r) * (2*CW+2)'(f1_bd_r);
    f2_n_r    <= f1_n_r;
    f2_bcs_r  <= f1_bcs_r;

    f3_op_r  <= f2_op_r;
    f3_den_r <= f2_op_r ? DEN_W'(f2_bcs_r) : (DEN_W'(f2_p1_r) * DEN_W'(f2_p2_r));
    f3_sq_r  <= SQ_W'(f2_diff_r) * SQ_W'(f2_diff_r);
    f3_n_r   <= f2_n_r;

    f4_op_r      <= f3_op_r;
    f4_err_r     <= (f3_den_r == '0);
    f4_den_r     <= f3_den_r;
    f4_num_chi_r <= f3_op_r ? NUM_W'({f3_sq_r, 14'd0}) : NUM_W'({prod_nxt, 14'd0});
    f4_num_phi_r <= {f3_sq_r, 32'd0};
  end

  assign out_valid   = v_r[3];
  assign out_op      = f4_op_r;
  assign out_err     = f4_err_r;
  assign out_den     = f4_den_r;
  assign out_num_chi = f4_num_chi_r;
  assign out_num_phi = f4_num_phi_r;

endmodule

[design/chi2x2_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating.
// No package dependencies; instantiated by the top level and chi2x2_pval.
module chi2x2_div #(
  parameter int W    = 102,
  parameter int Q_W  = 33,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [W-1:0]    num,
  input  logic [W-1:0]    den,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_valid,
  output logic [Q_W-1:0]  quo,
  output logic [SB_W-1:0] sb_out
);

  logic [Q_W:0]    v_r;
  logic [W-1:0]    rem_r [Q_W+1];
  logic [W-1:0]    den_r [Q_W+1];
  logic [Q_W-1:0]  q_r   [Q_W+1];
  logic            sat_r [Q_W+1];
  logic [SB_W-1:0] sb_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= (num >= (den << Q_W));
    sb_r[0]  <= sb_in;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [W-1:0]   trial;
    logic           ge;
    logic [W-1:0]   rem_nxt;
    logic [Q_W-1:0] q_nxt;

    assign trial   = den_r[j] << (Q_W-1-j);
    assign ge      = (rem_r[j] >= trial);
    assign rem_nxt = ge ? (rem_r[j] - trial) : rem_r[j];
    assign q_nxt   = {q_r[j][Q_W-2:0], ge};

    always_ff @(posedge clk) begin
      rem_r[j+1] <= rem_nxt;
      den_r[j+1] <= den_r[j];
      q_r[j+1]   <= q_nxt;
      sat_r[j+1] <= sat_r[j];
      sb_r[j+1]  <= sb_r[j];
    end
  end

  assign out_valid = v_r[Q_W];
  assign quo       = sat_r[Q_W] ? '1 : q_r[Q_W];
  assign sb_out    = sb_r[Q_W];

endmodule

[design/chi2x2_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// No package dependencies; instantiated by the top level.
module chi2x2_sqrt #(
  parameter int IN_W = 50,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   rad,
  input  logic [SB_W-1:0]   sb_in,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root,
  output logic [SB_W-1:0]   sb_out
);

  localparam int H = IN_W/2;

  logic [H:0]      v_r;
  logic [IN_W-1:0] rad_r  [H+1];
  logic [H+1:0]    rem_r  [H+1];
  logic [H-1:0]    root_r [H+1];
  logic [SB_W-1:0] sb_r   [H+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[H-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rad_r[0]  <= rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    sb_r[0]   <= sb_in;
  end

  for (genvar j = 0; j < H; j++) begin : g_stage
    logic [H+1:0] rem_sh;
    logic [H+1:0] trial;
    logic         ge;
    logic [H+1:0] rem_nxt;
    logic [H-1:0] root_nxt;

    assign rem_sh   = {rem_r[j][H-1:0], rad_r[j][IN_W-1 -: 2]};
    assign trial    = {root_r[j], 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_r[j][H-2:0], ge};

    always_ff @(posedge clk) begin
      rad_r[j+1]  <= rad_r[j] << 2;
      rem_r[j+1]  <= rem_nxt;
      root_r[j+1] <= root_nxt;
      sb_r[j+1]   <= sb_r[j];
    end
  end

  assign out_valid = v_r[H];
  assign root      = root_r[H];
  assign sb_out    = sb_r[H];

endmodule

[design/chi2x2_pval.sv]
// Two-sided p value from z: Horner polynomial, reciprocal, four squarings.
// Depends on chi2x2_pkg constants and the chi2x2_div divider.
module chi2x2_pval #(
  parameter int SB_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [chi2x2_pkg::Z_W-1:0]  z,
  input  logic [SB_W-1:0]             sb_in,
  output logic                        out_valid,
  output logic [chi2x2_pkg::P_W-1:0]  p,
  output logic [SB_W-1:0]             sb_out
);

  localparam int Z_W  = chi2x2_pkg::Z_W;
  localparam int P_W  = chi2x2_pkg::P_W;
  localparam int T_W  = 36;
  localparam int RD_W = T_W + P_W + 1;

  logic [6:0]      h_v_r;
  logic [Z_W-1:0]  h_z_r  [7];
  logic            h_zz_r [7];
  logic [SB_W-1:0] h_sb_r [7];
  logic [T_W-1:0]  h_t_r  [7];

  logic            dv_valid;
  logic [P_W-1:0]  dv_quo;
  logic [SB_W:0]   dv_sb;

  logic [3:0]      s_v_r;
  logic [P_W-1:0]  s_r    [4];
  logic            s_zz_r [4];
  logic [SB_W-1:0] s_sb_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= '0;
      s_v_r <= '0;
    end else begin
      h_v_r <= {h_v_r[5:0], in_valid};
      s_v_r <= {s_v_r[2:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    h_z_r[0]  <= z;
    h_zz_r[0] <= (z == '0);
    h_sb_r[0] <= sb_in;
    h_t_r[0]  <= T_W'(chi2x2_pkg::POLY_Q32[5]);
  end

  for (genvar s = 1; s <= 6; s++) begin : g_horner
    logic [T_W-1:0]     coef;
    logic [Z_W+T_W-1:0] prod;

    if (s == 6) begin : g_last
      assign coef = T_W'(chi2x2_pkg::P_ONE);
    end else begin : g_mid
      assign coef = T_W'(chi2x2_pkg::POLY_Q32[5-s]);
    end

    assign prod = (Z_W+T_W)'(h_z_r[s-1]) * (Z_W+T_W)'(h_t_r[s-1]);

    always_ff @(posedge clk) begin
      h_t_r[s]  <= coef + T_W'(prod >> 16);
      h_z_r[s]  <= h_z_r[s-1];
      h_zz_r[s] <= h_zz_r[s-1];
      h_sb_r[s] <= h_sb_r[s-1];
    end
  end

  chi2x2_div #(
    .W    (RD_W),
    .Q_W  (P_W),
    .SB_W (SB_W+1)
  ) u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h_v_r[6]),
    .num       (RD_W'(64'hFFFF_FFFF_FFFF_FFFF)),
    .den       (RD_W'(h_t_r[6])),
    .sb_in     ({h_zz_r[6], h_sb_r[6]}),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .sb_out    (dv_sb)
  );

  for (genvar k = 0; k < 4; k++) begin : g_square
    logic [P_W-1:0]   src;
    logic             src_zz;
    logic [SB_W-1:0]  src_sb;
    logic [2*P_W-1:0] prod;

    if (k == 0) begin : g_first
      assign src    = dv_quo;
      assign src_zz = dv_sb[SB_W];
      assign src_sb = dv_sb[SB_W-1:0];
    end else begin : g_next
      assign src    = s_r[k-1];
      assign src_zz = s_zz_r[k-1];
      assign src_sb = s_sb_r[k-1];
    end

    assign prod = (2*P_W)'(src) * (2*P_W)'(src);

    always_ff @(posedge clk) begin
      s_r[k]    <= P_W'(prod >> 32);
      s_zz_r[k] <= src_zz;
      s_sb_r[k] <= src_sb;
    end
  end

  assign out_valid = s_v_r[3];
  assign p         = s_zz_r[3] ? chi2x2_pkg::P_ONE : s_r[3];
  assign sb_out    = s_sb_r[3];

endmodule

[design/chi_square_2x2_test_unit.sv]
// Pearson 2x2 chi-square and McNemar test unit with phi and two-sided p.
// One word is accepted per cycle.
// The depth is set by the two 34-stage dividers and the 26-stage square root.
// busy stays low: the pipeline never stalls. Reset is synchronous, active low,
// and clears only the valid bits. Depends on chi2x2_pkg and the chi2x2_* units.
module chi_square_2x2_test_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  chi2x2_pkg::in_word_t  in_data,
  output logic                  out_strobe,
  output chi2x2_pkg::out_word_t out_data
);

  localparam int CW    = (COUNT_BITS < chi2x2_pkg::CNT_W) ? COUNT_BITS : chi2x2_pkg::CNT_W;
  localparam int NUM_W = 5*CW+16;
  localparam int DIV_W = (NUM_W > 4*CW+38) ? NUM_W : 4*CW+38;
  localparam int CHI_W = chi2x2_pkg::CHI_W;
  localparam int PHI_W = chi2x2_pkg::PHI_W;
  localparam int P_W   = chi2x2_pkg::P_W;
  localparam int Z_W   = chi2x2_pkg::Z_W;
  localparam int RAD_W = 50;
  localparam int RT_W  = RAD_W/2;

  logic              fr_valid, fr_op, fr_err;
  logic [4*CW+3:0]   fr_den;
  logic [NUM_W-1:0]  fr_num_chi;
  logic [4*CW+31:0]  fr_num_phi;

  logic              dc_valid;
  logic [P_W-1:0]    dc_quo, dp_quo;
  logic              dc_sb;
  logic              dp_sb;
  logic [CHI_W-1:0]  chi_val;

  logic              sz_valid;
  logic [RT_W-1:0]   z_root, phi_root;
  logic [CHI_W:0]    sz_sb;
  logic              sp_sb;
  logic [Z_W-1:0]    z_val;
  logic [PHI_W-1:0]  phi_val;

  logic              pv_valid;
  logic [P_W-1:0]    pv_p;
  logic [CHI_W+PHI_W:0] pv_sb;

  logic                  out_strobe_r;
  chi2x2_pkg::out_word_t out_data_r;

  assign busy = 1'b0;

  chi2x2_front #(.CW(CW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy),
    .in_word     (in_data),
    .out_valid   (fr_valid),
    .out_op      (fr_op),
    .out_err     (fr_err),
    .out_den     (fr_den),
    .out_num_chi (fr_num_chi),
    .out_num_phi (fr_num_phi)
  );

  chi2x2_div #(.W(DIV_W), .Q_W(P_W), .SB_W(1)) u_div_chi (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .num       (DIV_W'(fr_num_chi)),
    .den       (DIV_W'(fr_den)),
    .sb_in     (fr_err),
    .out_valid (dc_valid),
    .quo       (dc_quo),
    .sb_out    (dc_sb)
  );

  chi2x2_div #(.W(DIV_W), .Q_W(P_W), .SB_W(1)) u_div_phi (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .num       (DIV_W'(fr_num_phi)),
    .den       (DIV_W'(fr_den)),
    .sb_in     (fr_op),
    .out_valid (),
    .quo       (dp_quo),
    .sb_out    (dp_sb)
  );

  assign chi_val = dc_sb ? '0 : (dc_quo[P_W-1] ? '1 : dc_quo[CHI_W-1:0]);

  chi2x2_sqrt #(.IN_W(RAD_W), .SB_W(CHI_W+1)) u_sqrt_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dc_valid),
    .rad       ({chi_val, 18'd0}),
    .sb_in     ({chi_val, dc_sb}),
    .out_valid (sz_valid),
    .root      (z_root),
    .sb_out    (sz_sb)
  );

  chi2x2_sqrt #(.IN_W(RAD_W), .SB_W(1)) u_sqrt_phi (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dc_valid),
    .rad       (RAD_W'(dp_quo)),
    .sb_in     (dp_sb),
    .out_valid (),
    .root      (phi_root),
    .sb_out    (sp_sb)
  );

  assign z_val   = (z_root > RT_W'(chi2x2_pkg::Z_LIMIT)) ? chi2x2_pkg::Z_LIMIT
                                                         : z_root[Z_W-1:0];
  assign phi_val = (sp_sb || sz_sb[0]) ? '0 :
                   ((phi_root > RT_W'(16'hFFFF)) ? '1 : phi_root[PHI_W-1:0]);

  chi2x2_pval #(.SB_W(CHI_W+PHI_W+1)) u_pval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sz_valid),
    .z         (z_val),
    .sb_in     ({sz_sb[CHI_W:1], phi_val, sz_sb[0]}),
    .out_valid (pv_valid),
    .p         (pv_p),
    .sb_out    (pv_sb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.chi_square  <= pv_sb[CHI_W+PHI_W:PHI_W+1];
    out_data_r.phi_coeff   <= pv_sb[PHI_W:1];
    out_data_r.p_two_sided <= pv_sb[0] ? '0 : pv_p;
    out_data_r.div_error   <= pv_sb[0];
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

[design/chi2x2_checker.sv]
// Port-level checker for chi_square_2x2_test_unit, bound to the top level.
// Depends on chi2x2_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module chi2x2_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_strobe,
  input chi2x2_pkg::out_word_t out_data
);

  `CHI_ASSERT_IMPLIES(a_err_zero, clk, rst_n,
    out_strobe && out_data.div_error,
    out_data.chi_square == 32'd0 && out_data.phi_coeff == 16'd0 &&
    out_data.p_two_sided == 33'd0,
    "Error word carries nonzero results.")
  `CHI_ASSERT_IMPLIES(a_zero_chi, clk, rst_n,
    out_strobe && !out_data.div_error && out_data.chi_square == 32'd0,
    out_data.p_two_sided == chi2x2_pkg::P_ONE,
    "Zero statistic must give p of one.")
  `CHI_ASSERT_IMPLIES(a_sat_chi, clk, rst_n,
    out_strobe && !out_data.div_error && out_data.chi_square == 32'hFFFFFFFF,
    out_data.p_two_sided == 33'd0,
    "Saturated statistic must give p of zero.")
  `CHI_ASSERT_NEVER(a_p_range, clk, rst_n,
    out_strobe && out_data.p_two_sided > chi2x2_pkg::P_ONE,
    "p value above one.")

endmodule

bind chi_square_2x2_test_unit chi2x2_checker u_chk (.*);

[sim/chi_square_2x2_test_unit_tb.sv]
// Self-checking testbench for the chi-square 2x2 unit in Pearson and McNemar modes.
// It predicts chi, phi and p for each word and compares them with the strobed results.
// Depends on chi2x2_pkg and the chi_square_2x2_test_unit RTL.
module chi_square_2x2_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PEARSON = 1'b0;
  localparam logic OP_MCNEMAR = 1'b1;
  localparam int LATENCY = 110;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  chi2x2_pkg::in_word_t in_data;
  logic out_strobe;
  chi2x2_pkg::out_word_t out_data;

  chi2x2_pkg::out_word_t expected_q[$];
  int errors;
  int idle_cycles;

  chi_square_2x2_test_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_quotient(logic [191:0] num, logic [191:0] den, int bits);
    logic [191:0] q;
    q = num / den;
    if (q >= (192'd1 << bits)) return (64'd1 << bits) - 64'd1;
    return q[63:0];
  endfunction

  function automatic logic [32:0] two_sided_p(logic [31:0] chi);
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] r;
    logic [31:0] coef [6];
    coef = '{32'd214178625, 32'd90799929, 32'd14077298, 32'd163224, 32'd209984, 32'd23120};
    z = int_sqrt({14'd0, chi, 18'd0});
    if (z > 64'h80000) z = 64'h80000;
    if (z == 0) return 33'h1_0000_0000;
    t = 64'(coef[5]);
    for (int k = 4; k >= 0; k--) t = 64'(coef[k]) + ((z * t) >> 16);
    t = 64'h1_0000_0000 + ((z * t) >> 16);
    r = 64'hFFFF_FFFF_FFFF_FFFF / t;
    for (int k = 0; k < 4; k++) r = (r * r) >> 32;
    return r[32:0];
  endfunction

  function automatic chi2x2_pkg::out_word_t predict_tests(chi2x2_pkg::in_word_t w);
    chi2x2_pkg::out_word_t res;
    logic [191:0] a, b, c, d, diff, den;
    logic [63:0] phi;
    logic [63:0] chi;
    a = 192'(w.count_a); b = 192'(w.count_b); c = 192'(w.count_c); d = 192'(w.count_d);
    res = '0;
    if (w.op == OP_PEARSON) begin
      diff = (a * d > b * c) ? a * d - b * c : b * c - a * d;
      den = (a + b) * (c + d) * (a + c) * (b + d);
      if (den == 0) begin
        res.div_error = 1'b1;
      end else begin
        chi = sat_quotient((diff * diff * (a + b + c + d)) << 14, den, 32);
        res.chi_square = chi[31:0];
        phi = int_sqrt(sat_quotient((diff * diff) << 32, den, 33));
        res.phi_coeff = (phi > 64'hFFFF) ? 16'hFFFF : phi[15:0];
      end
    end else begin
      diff = (b > c) ? b - c : c - b;
      den = b + c;
      if (den == 0) begin
        res.div_error = 1'b1;
      end else begin
        chi = sat_quotient((diff * diff) << 14, den, 32);
        res.chi_square = chi[31:0];
      end
    end
    if (!res.div_error) res.p_two_sided = two_sided_p(res.chi_square);
    return res;
  endfunction

  task automatic send_table(logic op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [15:0] d);
    chi2x2_pkg::in_word_t w;
    int gap;
    w = '{op: op, count_a: a, count_b: b, count_c: c, count_d: d};
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_tests(w));
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(0, 1000));
      2: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_extremes();
    send_table(OP_PEARSON, 0, 0, 0, 0);
    send_table(OP_PEARSON, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_table(OP_PEARSON, 16'hFFFF, 0, 0, 16'hFFFF);
    send_table(OP_PEARSON, 0, 16'hFFFF, 16'hFFFF, 0);
    send_table(OP_PEARSON, 5, 0, 7, 0);
    send_table(OP_PEARSON, 10, 10, 10, 10);
    send_table(OP_PEARSON, 1, 2, 3, 4);
    send_table(OP_PEARSON, 16'hFFFF, 1, 1, 16'hFFFF);
  endtask

  task automatic test_mcnemar();
    send_table(OP_MCNEMAR, 0, 0, 0, 0);
    send_table(OP_MCNEMAR, 16'hFFFF, 0, 0, 16'hFFFF);
    send_table(OP_MCNEMAR, 3, 16'hFFFF, 0, 9);
    send_table(OP_MCNEMAR, 0, 0, 16'hFFFF, 0);
    send_table(OP_MCNEMAR, 0, 16'hFFFF, 16'hFFFF, 0);
    send_table(OP_MCNEMAR, 0, 1, 0, 0);
    send_table(OP_MCNEMAR, 0, 12, 10, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 2000; i++) begin
      send_table(logic'($urandom_range(0, 1)), rand_count(), rand_count(), rand_count(),
                 rand_count());
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    chi2x2_pkg::out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_data.chi_square !== exp_w.chi_square) begin
          $display("%0t: chi_square expected %h actual %h", $time, exp_w.chi_square,
                   out_data.chi_square);
          errors++;
        end
        if (out_data.phi_coeff !== exp_w.phi_coeff) begin
          $display("%0t: phi_coeff expected %h actual %h", $time, exp_w.phi_coeff,
                   out_data.phi_coeff);
          errors++;
        end
        if (out_data.p_two_sided !== exp_w.p_two_sided) begin
          $display("%0t: p_two_sided expected %h actual %h", $time, exp_w.p_two_sided,
                   out_data.p_two_sided);
          errors++;
        end
        if (out_data.div_error !== exp_w.div_error) begin
          $display("%0t: div_error expected %b actual %b", $time, exp_w.div_error,
                   out_data.div_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_mcnemar();
    test_random();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
